// File: rtl/core/q2e_pkg.sv
package q2e_pkg;

  // Field widths
  localparam int QW      = 16;
  localparam int PW      = 2 * QW;
  localparam int THR_W   = 30;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;
  localparam int ROLL_W  = 18;

  // Datapath widths
  localparam int TW     = PW + 1;       // z*x - w*y in Q.30
  localparam int OW     = PW + 2;       // doubled sums in Q.30
  localparam int CW     = 38;           // CORDIC x/y datapath
  localparam int ZW     = 34;           // angle accumulator, deg with 24 frac bits
  localparam int RW     = ZW + 2;       // roll accumulator
  localparam int SW     = 32;           // clamped 2t
  localparam int REM_W  = 62;           // square-root remainder
  localparam int SQR_W  = 31;           // square-root result

  localparam int SQRT_STEPS   = 31;
  localparam int CORDIC_STEPS = 26;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

  localparam int ACC_FRAC   = 24;
  localparam int ANGLE_FRAC = 7;
  localparam int RND_SH     = ACC_FRAC - ANGLE_FRAC;
  localparam int AX_SH      = 30 - (QW - 1);

  localparam logic [THR_W-1:0]    THR_RESET = 30'd536870375;
  localparam logic signed [OW-1:0] ONE_Q30  = OW'(64'sd1 << 30);
  localparam logic signed [ZW-1:0] DEG90    = 34'sd1509949440;
  localparam logic signed [ZW-1:0] DEG180   = 34'sd3019898880;

  // Pole codes
  typedef enum logic [1:0] {
    POLE_NONE = 2'd0,
    POLE_NEG  = 2'd1,
    POLE_POS  = 2'd2
  } pole_t;

  // Request travelling through the front end and the square root
  typedef struct packed {
    logic                  valid;
    pole_t                 pole;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  by;
    logic signed [CW-1:0]  bx;
    logic signed [SW-1:0]  s;
  } side_t;

  // Control travelling beside the CORDIC lanes
  typedef struct packed {
    logic  valid;
    pole_t pole;
  } tag_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd754974720;
      1:  r = 34'sd445687602;
      2:  r = 34'sd235489088;
      3:  r = 34'sd119537938;
      4:  r = 34'sd60000934;
      5:  r = 34'sd30029717;
      6:  r = 34'sd15018523;
      7:  r = 34'sd7509720;
      8:  r = 34'sd3754917;
      9:  r = 34'sd1877466;
      10: r = 34'sd938734;
      11: r = 34'sd469367;
      12: r = 34'sd234684;
      13: r = 34'sd117342;
      14: r = 34'sd58671;
      15: r = 34'sd29335;
      16: r = 34'sd14668;
      17: r = 34'sd7334;
      18: r = 34'sd3667;
      19: r = 34'sd1833;
      20: r = 34'sd917;
      21: r = 34'sd458;
      22: r = 34'sd229;
      23: r = 34'sd115;
      24: r = 34'sd57;
      25: r = 34'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/quaternion_to_euler_angles_top.sv
// Quaternion to Euler angles. Takes one Q1.15 quaternion (x, y, z, w) per
// cycle while in_stall is low and returns pitch, yaw and roll in degrees
// with 7 fraction bits plus a pole code (0 regular, 1 pitch -90, 2 pitch
// +90). Fully pipelined: one request per clock unless stalled (4 front-end
// stages for the products, singularity test and 1 - s^2, 31 square-root
// stages, 27 CORDIC stages in each of three parallel atan2 lanes, 2 output
// stages). out_stall freezes the whole pipeline while a result is held;
// in_stall follows it. The threshold register (Q0.30, reset 0.4999995) is
// written through the cfg port, which is always ready; write it only while the pipe is empty.
module quaternion_to_euler_angles_top
  import q2e_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [QW-1:0]      in_quat_x,
  input  logic signed [QW-1:0]      in_quat_y,
  input  logic signed [QW-1:0]      in_quat_z,
  input  logic signed [QW-1:0]      in_quat_w,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PITCH_W-1:0] out_pitch_deg,
  output logic signed [YAW_W-1:0]   out_yaw_deg,
  output logic signed [ROLL_W-1:0]  out_roll_deg,
  output logic [1:0]                out_pole_case,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [THR_W-1:0]          cfg_data
);

  // Global advance: hold everything while a result waits
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Threshold register
  logic [THR_W-1:0] thr_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  side_t            side_f, side_s;
  logic [REM_W-1:0] rem;
  logic [SQR_W-1:0] c;

  q2e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .quat_x   (in_quat_x),
    .quat_y   (in_quat_y),
    .quat_z   (in_quat_z),
    .quat_w   (in_quat_w),
    .thr      (thr_r),
    .side_o   (side_f),
    .rem_o    (rem)
  );

  q2e_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (side_f),
    .rem_i  (rem),
    .side_o (side_s),
    .c_o    (c)
  );

  // Three atan2 lanes: yaw, roll (or half-angle at the poles), pitch
  logic signed [ZW-1:0] yaw_z, b_z, pitch_z;
  logic signed [CW-1:0] c_x;
  assign c_x = CW'($signed({1'b0, c}));

  q2e_cordic u_cordic_yaw (
    .clk (clk),
    .en  (en),
    .y_i (side_s.ay),
    .x_i (side_s.ax),
    .z_o (yaw_z)
  );

  q2e_cordic u_cordic_roll (
    .clk (clk),
    .en  (en),
    .y_i (side_s.by),
    .x_i (side_s.bx),
    .z_o (b_z)
  );

  q2e_cordic u_cordic_pitch (
    .clk (clk),
    .en  (en),
    .y_i (CW'(side_s.s)),
    .x_i (c_x),
    .z_o (pitch_z)
  );

  // Valid and pole ride alongside the CORDIC lanes
  tag_t tag_r [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CORDIC_LAT; k++) begin
        tag_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      tag_r[0].valid <= side_s.valid;
      tag_r[0].pole  <= side_s.pole;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  q2e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .tag_i         (tag_r[CORDIC_STEPS]),
    .yaw_z         (yaw_z),
    .b_z           (b_z),
    .pitch_z       (pitch_z),
    .out_valid     (out_valid),
    .out_pitch_deg (out_pitch_deg),
    .out_yaw_deg   (out_yaw_deg),
    .out_roll_deg  (out_roll_deg),
    .out_pole_case (out_pole_case)
  );

endmodule

// File: rtl/core/q2e_front.sv
module q2e_front
  import q2e_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [QW-1:0]    quat_x,
  input  logic signed [QW-1:0]    quat_y,
  input  logic signed [QW-1:0]    quat_z,
  input  logic signed [QW-1:0]    quat_w,
  input  logic [THR_W-1:0]        thr,
  output side_t                   side_o,
  output logic [REM_W-1:0]        rem_o
);

  // Stage 1: component products, Q.30
  logic                 v1_r;
  logic signed [PW-1:0] p_zx_r, p_wy_r, p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xx_r;
  logic signed [QW-1:0] qx1_r, qw1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_valid;
      p_zx_r <= quat_z * quat_x;
      p_wy_r <= quat_w * quat_y;
      p_wz_r <= quat_w * quat_z;
      p_xy_r <= quat_x * quat_y;
      p_yy_r <= quat_y * quat_y;
      p_zz_r <= quat_z * quat_z;
      p_wx_r <= quat_w * quat_x;
      p_yz_r <= quat_y * quat_z;
      p_xx_r <= quat_x * quat_x;
      qx1_r  <= quat_x;
      qw1_r  <= quat_w;
    end
  end

  // Stage 2: singularity test, atan2 operands, pole decision, clamped 2t
  logic signed [TW-1:0] test, thr_s;
  logic signed [OW-1:0] yy, yx, ry, rx, s2;
  pole_t                pole_nxt;
  logic signed [SW-1:0] s_nxt;

  always_comb begin
    test  = TW'(p_zx_r) - TW'(p_wy_r);
    thr_s = TW'($signed({1'b0, thr}));
    yy    = (OW'(p_wz_r) + OW'(p_xy_r)) <<< 1;
    yx    = ONE_Q30 - ((OW'(p_yy_r) + OW'(p_zz_r)) <<< 1);
    ry    = -((OW'(p_wx_r) + OW'(p_yz_r)) <<< 1);
    rx    = ONE_Q30 - ((OW'(p_xx_r) + OW'(p_yy_r)) <<< 1);
    if (test > thr_s) begin
      pole_nxt = POLE_POS;
    end else if (test < -thr_s) begin
      pole_nxt = POLE_NEG;
    end else begin
      pole_nxt = POLE_NONE;
    end
    s2 = OW'(test) <<< 1;
    if (s2 > ONE_Q30) begin
      s2 = ONE_Q30;
    end else if (s2 < -ONE_Q30) begin
      s2 = -ONE_Q30;
    end
    s_nxt = SW'(s2);
  end

  logic                 v2_r;
  pole_t                pole2_r;
  logic signed [CW-1:0] yy2_r, yx2_r, ry2_r, rx2_r, ax2_r, aw2_r;
  logic signed [SW-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      pole2_r <= pole_nxt;
      yy2_r   <= CW'(yy);
      yx2_r   <= CW'(yx);
      ry2_r   <= CW'(ry);
      rx2_r   <= CW'(rx);
      ax2_r   <= CW'(qx1_r) <<< AX_SH;
      aw2_r   <= CW'(qw1_r) <<< AX_SH;
      s2_r    <= s_nxt;
    end
  end

  // Stage 3: square of s, second lane operand select
  side_t                side3_nxt, side3_r, side4_r;
  logic signed [2*SW-1:0] sq_nxt, sq3_r;

  always_comb begin
    sq_nxt          = s2_r * s2_r;
    side3_nxt.valid = v2_r;
    side3_nxt.pole  = pole2_r;
    side3_nxt.ay    = yy2_r;
    side3_nxt.ax    = yx2_r;
    side3_nxt.s     = s2_r;
    if (pole2_r == POLE_NONE) begin
      side3_nxt.by = ry2_r;
      side3_nxt.bx = rx2_r;
    end else begin
      side3_nxt.by = ax2_r;
      side3_nxt.bx = aw2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else if (en) begin
      side3_r <= side3_nxt;
      sq3_r   <= sq_nxt;
    end
  end

  // Stage 4: radicand 1 - s^2
  logic [REM_W-1:0] rem4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r.valid <= 1'b0;
    end else if (en) begin
      side4_r <= side3_r;
      rem4_r  <= (REM_W'(1) << 60) - REM_W'(sq3_r[60:0]);
    end
  end

  assign side_o = side4_r;
  assign rem_o  = rem4_r;

endmodule

// File: rtl/core/q2e_sqrt.sv
module q2e_sqrt
  import q2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  side_t              side_i,
  input  logic [REM_W-1:0]   rem_i,
  output side_t              side_o,
  output logic [SQR_W-1:0]   c_o
);

  side_t            side_r [SQRT_STEPS];
  logic [REM_W-1:0] v_r    [SQRT_STEPS];
  logic [REM_W-1:0] res_r  [SQRT_STEPS];

  // One result bit per stage, digit-by-digit integer square root
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_st
    localparam logic [REM_W-1:0] BITV = REM_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [REM_W-1:0] v_in, r_in, trial, v_nxt, r_nxt;
    side_t            s_in;

    if (i == 0) begin : g_first
      assign v_in = rem_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_rest
      assign v_in = v_r[i-1];
      assign r_in = res_r[i-1];
      assign s_in = side_r[i-1];
    end

    always_comb begin
      trial = r_in + BITV;
      if (v_in >= trial) begin
        v_nxt = v_in - trial;
        r_nxt = (r_in >> 1) + BITV;
      end else begin
        v_nxt = v_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else if (en) begin
        side_r[i] <= s_in;
        v_r[i]    <= v_nxt;
        res_r[i]  <= r_nxt;
      end
    end
  end

  assign side_o = side_r[SQRT_STEPS-1];
  assign c_o    = res_r[SQRT_STEPS-1][SQR_W-1:0];

endmodule

// File: rtl/core/q2e_cordic.sv
module q2e_cordic
  import q2e_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_r    [CORDIC_LAT];
  logic signed [CW-1:0] y_r    [CORDIC_LAT];
  logic signed [ZW-1:0] z_r    [CORDIC_LAT];
  logic                 done_r [CORDIC_LAT];

  // Axis cases and half-plane pre-rotation
  logic signed [CW-1:0] pre_x, pre_y;
  logic signed [ZW-1:0] pre_z;
  logic                 pre_done;

  always_comb begin
    pre_x    = x_i;
    pre_y    = y_i;
    pre_z    = '0;
    pre_done = 1'b0;
    if (y_i == '0) begin
      pre_done = 1'b1;
      pre_z    = (x_i < 0) ? DEG180 : '0;
    end else if (x_i == '0) begin
      pre_done = 1'b1;
      pre_z    = (y_i > 0) ? DEG90 : -DEG90;
    end else if (x_i < 0) begin
      pre_z = (y_i > 0) ? DEG180 : -DEG180;
      pre_x = -x_i;
      pre_y = -y_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= pre_x;
      y_r[0]    <= pre_y;
      z_r[0]    <= pre_z;
      done_r[0] <= pre_done;
    end
  end

  // Vectoring micro-rotations, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    localparam logic signed [ZW-1:0] ANG = atan_tab(i);
    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (done_r[i]) begin
        x_nxt = x_r[i];
        y_nxt = y_r[i];
        z_nxt = z_r[i];
      end else if (y_r[i] > 0) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ANG;
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        done_r[i+1] <= done_r[i];
      end
    end
  end

  assign z_o = z_r[CORDIC_STEPS];

endmodule

// File: rtl/core/q2e_back.sv
module q2e_back
  import q2e_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  tag_t                      tag_i,
  input  logic signed [ZW-1:0]      yaw_z,
  input  logic signed [ZW-1:0]      b_z,
  input  logic signed [ZW-1:0]      pitch_z,
  output logic                      out_valid,
  output logic signed [PITCH_W-1:0] out_pitch_deg,
  output logic signed [YAW_W-1:0]   out_yaw_deg,
  output logic signed [ROLL_W-1:0]  out_roll_deg,
  output logic [1:0]                out_pole_case
);

  localparam logic signed [RW-1:0] RND_HALF  = RW'(1) <<< (RND_SH - 1);
  localparam logic signed [RW-1:0] PITCH_LIM = RW'(90 <<< ANGLE_FRAC);
  localparam logic signed [RW-1:0] YAW_LIM   = RW'(180 <<< ANGLE_FRAC);
  localparam logic signed [RW-1:0] ROLL_LIM  = RW'(540 <<< ANGLE_FRAC);

  // Round half up to the output resolution, then clamp to +-lim
  function automatic logic signed [RW-1:0] round_clamp(
      input logic signed [RW-1:0] acc, input logic signed [RW-1:0] lim);
    logic signed [RW-1:0] v;
    v = (acc + RND_HALF) >>> RND_SH;
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v;
  endfunction

  // Stage 1: pick pitch, assemble roll
  logic signed [RW-1:0] roll_nxt, pitch_nxt;

  always_comb begin
    case (tag_i.pole)
      POLE_NEG: begin
        pitch_nxt = RW'(-DEG90);
        roll_nxt  = -RW'(yaw_z) - (RW'(b_z) <<< 1);
      end
      POLE_POS: begin
        pitch_nxt = RW'(DEG90);
        roll_nxt  = RW'(yaw_z) - (RW'(b_z) <<< 1);
      end
      default: begin
        pitch_nxt = RW'(pitch_z);
        roll_nxt  = RW'(b_z);
      end
    endcase
  end

  logic                 v1_r;
  pole_t                pole1_r;
  logic signed [RW-1:0] pitch1_r, yaw1_r, roll1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r     <= tag_i.valid;
      pole1_r  <= tag_i.pole;
      pitch1_r <= pitch_nxt;
      yaw1_r   <= RW'(yaw_z);
      roll1_r  <= roll_nxt;
    end
  end

  // Stage 2: output register
  logic signed [RW-1:0] pitch_v, yaw_v, roll_v;
  logic                       out_valid_r;
  logic signed [PITCH_W-1:0]  pitch_r;
  logic signed [YAW_W-1:0]    yaw_r;
  logic signed [ROLL_W-1:0]   roll_r;
  pole_t                      pole_r;

  always_comb begin
    pitch_v = round_clamp(pitch1_r, PITCH_LIM);
    yaw_v   = round_clamp(yaw1_r, YAW_LIM);
    roll_v  = round_clamp(roll1_r, ROLL_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v1_r;
      pitch_r     <= pitch_v[PITCH_W-1:0];
      yaw_r       <= yaw_v[YAW_W-1:0];
      roll_r      <= roll_v[ROLL_W-1:0];
      pole_r      <= pole1_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pitch_deg = pitch_r;
  assign out_yaw_deg   = yaw_r;
  assign out_roll_deg  = roll_r;
  assign out_pole_case = pole_r;

endmodule
